[hdl/jep_pkg.sv]
`default_nettype none
package jep_pkg;

    localparam int DIGIT_W  = 8;
    localparam int MAX_DEG  = 8;
    localparam int ELEM_W   = 12;
    localparam int MAP_AW   = 12;
    localparam int ACC_W    = 32;

    localparam logic signed [1:0] ENTRY_ZERO = 2'sb00;
    localparam logic signed [1:0] ENTRY_POS  = 2'sb01;
    localparam logic signed [1:0] ENTRY_NEG  = 2'sb11;

    typedef enum logic [1:0] {
        CFG_FIELD_CHAR = 2'd0,
        CFG_EXT_DEGREE = 2'd1,
        CFG_MODULUS    = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic [DIGIT_W-1:0] x;
        logic [DIGIT_W-1:0] y;
    } t_mm_req;

    typedef struct packed {
        logic              start;
        logic [ELEM_W-1:0] val;
    } t_div_req;

endpackage
`default_nettype wire

[hdl/jep_ifs.sv]
`default_nettype none
interface jep_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [11:0] element_a;
    logic [11:0] element_b;
    modport source (output valid, output mode, output element_a, output element_b, input ready);
    modport sink   (input valid, input mode, input element_a, input element_b, output ready);
endinterface

interface jep_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] entry;
    logic              error;
    modport source (output valid, output entry, output error, input ready);
    modport sink   (input valid, input entry, input error, output ready);
endinterface
`default_nettype wire

[hdl/jep_div.sv]
`default_nettype none
module jep_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire jep_pkg::t_div_req         i_req,
    input  wire logic [jep_pkg::DIGIT_W-1:0] i_p,
    output logic                           o_done,
    output logic [jep_pkg::ELEM_W-1:0]     o_quo,
    output logic [jep_pkg::DIGIT_W-1:0]    o_rem
);
    import jep_pkg::*;

    // Restoring division, one quotient bit per cycle.
    logic [ELEM_W-1:0]  r_quo;
    logic [DIGIT_W-1:0] r_rem;
    logic [3:0]         r_cnt;
    logic               r_run;
    logic               r_done;
    logic [DIGIT_W:0]   rem2;
    logic               ge;
    logic [DIGIT_W:0]   rem_sub;

    assign rem2    = {r_rem, r_quo[ELEM_W-1]};
    assign ge      = rem2 >= {1'b0, i_p};
    assign rem_sub = rem2 - {1'b0, i_p};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_quo <= i_req.val;
                r_rem <= '0;
                r_cnt <= '0;
            end else if (r_run) begin
                r_rem <= ge ? rem_sub[DIGIT_W-1:0] : rem2[DIGIT_W-1:0];
                r_quo <= {r_quo[ELEM_W-2:0], ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(ELEM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[hdl/jep_mulmod.sv]
`default_nettype none
module jep_mulmod (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire jep_pkg::t_mm_req            i_req,
    input  wire logic [jep_pkg::DIGIT_W-1:0] i_p,
    output logic                             o_done,
    output logic [jep_pkg::DIGIT_W-1:0]      o_prod
);
    import jep_pkg::*;

    // Bit-serial modular multiply, multiplier bits taken most significant first.
    // The multiplicand must already be below p; the multiplier may be any byte.
    logic [DIGIT_W-1:0] r_acc;
    logic [DIGIT_W-1:0] r_x;
    logic [DIGIT_W-1:0] r_y;
    logic [2:0]         r_cnt;
    logic               r_run;
    logic               r_done;
    logic [DIGIT_W+1:0] t;
    logic [DIGIT_W+1:0] p_ext;
    logic [DIGIT_W+1:0] t_red;

    assign p_ext = {2'b00, i_p};
    assign t     = {1'b0, r_acc, 1'b0} + (r_y[DIGIT_W-1] ? {2'b00, r_x} : '0);

    always_comb begin
        if (t >= {p_ext[DIGIT_W:0], 1'b0}) begin
            t_red = t - {p_ext[DIGIT_W:0], 1'b0};
        end else if (t >= p_ext) begin
            t_red = t - p_ext;
        end else begin
            t_red = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_acc <= '0;
                r_x   <= i_req.x;
                r_y   <= i_req.y;
                r_cnt <= '0;
            end else if (r_run) begin
                r_acc <= t_red[DIGIT_W-1:0];
                r_y   <= {r_y[DIGIT_W-2:0], 1'b0};
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'(DIGIT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

[hdl/jep_map.sv]
`default_nettype none
module jep_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_we,
    input  wire logic [jep_pkg::MAP_AW-1:0] i_waddr,
    input  wire logic [jep_pkg::MAP_AW-1:0] i_raddr,
    output logic                            o_rdata,
    output logic                            o_busy
);
    import jep_pkg::*;

    // Square bitmap; cleared one entry per cycle after reset and on request.
    logic                r_mem [2**MAP_AW];
    logic [MAP_AW-1:0]   r_cnt;
    logic                r_busy;
    logic                r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_clear) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + MAP_AW'(1);
            if (r_cnt == '1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt] <= 1'b0;
        end else if (i_we) begin
            r_mem[i_waddr] <= 1'b1;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;
endmodule
`default_nettype wire

[hdl/jacobsthal_entry_gf_pm_core.sv]
`default_nettype none
// Jacobsthal entry generator over GF(p^m).
// Input channel i_in carries a transaction of mode, element_a and element_b. In record
// mode the square of element_a, reduced by the monic modulus, is marked in a 4096-entry
// bitmap; in query mode the entry for (a, b) is returned: 0 on the diagonal, +1 when the
// digitwise difference a-b is marked, -1 otherwise. Output channel o_out carries one
// transaction (entry, error) per input transaction; error flags an index not below p^m.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data and must only be
// written while the block is idle; any write to a listed register clears the bitmap.
// One transaction is processed at a time. Digits are extracted with a bit-serial divider
// (one division per digit and operand), squaring takes m*m serial modular multiplies,
// reduction uses the same serial multiplier and repacking does a bit-serial multiply by
// p per digit. Queries need only the division, the digit difference and repacking.
// After reset and after each write to a listed register the bitmap is cleared one entry
// per cycle, during which no transaction is accepted.
// A result waits in the output register until taken; a stalled receiver holds the block.
module jacobsthal_entry_gf_pm_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    jep_in_if.sink           i_in,
    jep_out_if.source        o_out
);
    import jep_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_DIFF = 9'b000000100,
        S_SQ   = 9'b000001000,
        S_RED  = 9'b000010000,
        S_PACK = 9'b000100000,
        S_MAP  = 9'b001000000,
        S_RD   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    function automatic logic [DIGIT_W-1:0] add_mod(input logic [DIGIT_W-1:0] a,
                                                  input logic [DIGIT_W-1:0] b,
                                                  input logic [DIGIT_W-1:0] p);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[DIGIT_W-1:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] sub_mod(input logic [DIGIT_W-1:0] a,
                                                  input logic [DIGIT_W-1:0] b,
                                                  input logic [DIGIT_W-1:0] p);
        logic [DIGIT_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, p} - {1'b0, b};
        end
        return s[DIGIT_W-1:0];
    endfunction

    // Configuration registers.
    logic [7:0]  r_p;
    logic [3:0]  r_m;
    logic [63:0] r_q;
    logic [7:0]  p_eff;
    logic [3:0]  m_eff;
    logic        cfg_hit;

    assign p_eff   = (r_p < 8'd2) ? 8'd2 : r_p;
    assign m_eff   = (r_m == 4'd0) ? 4'd1 : ((r_m > 4'(MAX_DEG)) ? 4'(MAX_DEG) : r_m);
    assign cfg_hit = i_cfg_we && (t_cfg_idx'(i_cfg_idx) != CFG_UNUSED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= 8'd3;
            r_m <= 4'd1;
            r_q <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FIELD_CHAR: r_p <= i_cfg_data[7:0];
                CFG_EXT_DEGREE: r_m <= i_cfg_data[3:0];
                CFG_MODULUS:    r_q <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state.
    t_state             r_state;
    logic               r_mode;
    logic [ELEM_W-1:0]  r_a;
    logic [ELEM_W-1:0]  r_b;
    logic [ELEM_W-1:0]  r_cur;
    logic               r_which;
    logic               r_err;
    logic               r_wait;
    logic [1:0]         r_ph;
    logic [3:0]         r_i;
    logic [3:0]         r_j;
    logic [3:0]         r_k;
    logic [2:0]         r_bc;
    logic [DIGIT_W-1:0] r_x;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_v;
    logic signed [1:0]  r_entry;
    logic [DIGIT_W-1:0] r_da [MAX_DEG];
    logic [DIGIT_W-1:0] r_db [MAX_DEG];
    logic [DIGIT_W-1:0] r_r  [2*MAX_DEG];

    // Shared units.
    t_div_req           div_req;
    logic               div_done;
    logic [ELEM_W-1:0]  div_quo;
    logic [DIGIT_W-1:0] div_rem;
    t_mm_req            mm_req;
    logic               mm_done;
    logic [DIGIT_W-1:0] mm_prod;
    logic               map_busy;
    logic               map_rdata;
    logic               map_we;

    logic               accept;
    logic               in_ready;
    logic [3:0]         pos;
    logic [3:0]         r_idx;
    logic [DIGIT_W-1:0] r_rd;
    logic [2:0]         d_idx;
    logic [DIGIT_W-1:0] d_rd;
    logic [DIGIT_W-1:0] coeff;
    logic               err_n;
    logic               in_range;
    logic [3:0]         red_top;

    assign in_ready = (r_state == S_IDLE) && !map_busy && !i_cfg_we;
    assign accept   = i_in.valid && in_ready;
    assign pos      = r_i - m_eff + r_k;
    assign coeff    = r_q[8*r_k[2:0] +: 8];
    assign err_n    = r_err || (r_cur != '0);
    assign in_range = (r_v[ACC_W-1:MAP_AW] == '0);
    assign red_top  = 4'({1'b0, m_eff, 1'b0} - 5'd2);

    // Single read port on the partial-product digits.
    always_comb begin
        case (r_state)
            S_SQ:    r_idx = r_i + r_j;
            S_RED:   r_idx = (r_ph == 2'd0) ? r_i : pos;
            S_PACK:  r_idx = r_k;
            default: r_idx = '0;
        endcase
    end
    assign r_rd  = r_r[r_idx];
    assign d_idx = (r_ph == 2'd0) ? r_i[2:0] : r_j[2:0];
    assign d_rd  = r_da[d_idx];

    assign div_req.start = (r_state == S_DIV) && !r_wait && (r_k != m_eff);
    assign div_req.val   = r_cur;

    always_comb begin
        mm_req.start = 1'b0;
        mm_req.x     = r_x;
        mm_req.y     = d_rd;
        if ((r_state == S_SQ) && (r_ph == 2'd1) && !r_wait) begin
            mm_req.start = 1'b1;
        end else if ((r_state == S_RED) && (r_ph == 2'd1) && !r_wait) begin
            mm_req.start = 1'b1;
            mm_req.y     = coeff;
        end
    end

    assign map_we = (r_state == S_MAP) && !r_mode && in_range;

    jep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_p     (p_eff),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    jep_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .i_p     (p_eff),
        .o_done  (mm_done),
        .o_prod  (mm_prod)
    );

    jep_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_hit),
        .i_we    (map_we),
        .i_waddr (r_v[MAP_AW-1:0]),
        .i_raddr (r_v[MAP_AW-1:0]),
        .o_rdata (map_rdata),
        .o_busy  (map_busy)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DIV;
                        r_wait  <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (r_wait) begin
                        if (div_done) begin
                            r_wait <= 1'b0;
                        end
                    end else if (r_k == m_eff) begin
                        if (!r_which && r_mode) begin
                            r_state <= S_DIV;
                        end else if (err_n) begin
                            r_state <= S_OUT;
                        end else if (!r_mode) begin
                            r_state <= S_SQ;
                        end else if (r_a == r_b) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIFF;
                        end
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_DIFF: r_state <= S_PACK;
                S_SQ: begin
                    if (r_wait) begin
                        if (mm_done) begin
                            r_wait <= 1'b0;
                            if ((r_j == m_eff - 4'd1) && (r_i == m_eff - 4'd1)) begin
                                r_state <= S_RED;
                            end
                        end
                    end else if (r_ph == 2'd1) begin
                        r_wait <= 1'b1;
                    end
                end
                S_RED: begin
                    if (r_wait) begin
                        if (mm_done) begin
                            r_wait <= 1'b0;
                        end
                    end else if (r_ph == 2'd0) begin
                        if (r_i < m_eff) begin
                            r_state <= S_PACK;
                        end
                    end else begin
                        r_wait <= 1'b1;
                    end
                end
                S_PACK: begin
                    if ((r_ph == 2'd2) && (r_k == 4'd0)) begin
                        r_state <= S_MAP;
                    end
                end
                S_MAP:   r_state <= r_mode ? S_RD : S_OUT;
                S_RD:    r_state <= S_OUT;
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mode  <= i_in.mode;
                r_a     <= i_in.element_a;
                r_b     <= i_in.element_b;
                r_cur   <= i_in.element_a;
                r_which <= 1'b0;
                r_err   <= 1'b0;
                r_k     <= '0;
            end
            S_DIV: begin
                if (r_wait) begin
                    if (div_done) begin
                        if (r_which) begin
                            r_db[r_k[2:0]] <= div_rem;
                        end else begin
                            r_da[r_k[2:0]] <= div_rem;
                        end
                        r_cur <= div_quo;
                        r_k   <= r_k + 4'd1;
                    end
                end else if (r_k == m_eff) begin
                    r_err <= err_n;
                    if (!r_which && r_mode) begin
                        r_which <= 1'b1;
                        r_cur   <= r_b;
                        r_k     <= '0;
                    end else begin
                        r_entry <= ENTRY_ZERO;
                        for (int n = 0; n < 2*MAX_DEG; n++) begin
                            r_r[n] <= '0;
                        end
                        r_i  <= '0;
                        r_j  <= '0;
                        r_ph <= 2'd0;
                    end
                end
            end
            S_DIFF: begin
                // Lanes are independent: one digit difference each.
                for (int n = 0; n < MAX_DEG; n++) begin
                    r_r[n] <= sub_mod(r_da[n], r_db[n], p_eff);
                end
                r_k  <= m_eff - 4'd1;
                r_ph <= 2'd0;
                r_v  <= '0;
            end
            S_SQ: begin
                if (r_wait) begin
                    if (mm_done) begin
                        r_r[r_idx] <= add_mod(r_rd, mm_prod, p_eff);
                        r_ph       <= 2'd0;
                        if (r_j == m_eff - 4'd1) begin
                            r_j <= '0;
                            if (r_i == m_eff - 4'd1) begin
                                r_i <= red_top;
                            end else begin
                                r_i <= r_i + 4'd1;
                            end
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                    end
                end else if (r_ph == 2'd0) begin
                    r_x  <= d_rd;
                    r_ph <= 2'd1;
                end
            end
            S_RED: begin
                if (r_wait) begin
                    if (mm_done) begin
                        r_r[r_idx] <= sub_mod(r_rd, mm_prod, p_eff);
                        if (r_k == m_eff - 4'd1) begin
                            r_i  <= r_i - 4'd1;
                            r_ph <= 2'd0;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end else if (r_ph == 2'd0) begin
                    if (r_i < m_eff) begin
                        r_k <= m_eff - 4'd1;
                        r_v <= '0;
                    end else begin
                        r_x        <= r_rd;
                        r_r[r_idx] <= '0;
                        r_k        <= '0;
                        r_ph       <= 2'd1;
                    end
                end
            end
            S_PACK: begin
                // v = v * p + digit, the multiply done one bit of p per cycle.
                case (r_ph)
                    2'd0: begin
                        r_acc <= '0;
                        r_bc  <= '0;
                        r_ph  <= 2'd1;
                    end
                    2'd1: begin
                        r_acc <= {r_acc[ACC_W-2:0], 1'b0}
                               + (p_eff[3'(DIGIT_W - 1) - r_bc] ? r_v : '0);
                        r_bc  <= r_bc + 3'd1;
                        if (r_bc == 3'(DIGIT_W - 1)) begin
                            r_ph <= 2'd2;
                        end
                    end
                    default: begin
                        r_v  <= r_acc + ACC_W'(r_rd);
                        r_ph <= 2'd0;
                        if (r_k != 4'd0) begin
                            r_k <= r_k - 4'd1;
                        end
                    end
                endcase
            end
            S_MAP: begin
                r_entry <= ENTRY_ZERO;
            end
            S_RD: begin
                r_entry <= (in_range && map_rdata) ? ENTRY_POS : ENTRY_NEG;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.entry = r_entry;
    assign o_out.error = r_err;

    // An error result never carries a nonzero entry.
    a_err_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.error |-> o_out.entry == ENTRY_ZERO)
        else $error("error result with nonzero entry");

    // No new transaction while a result is pending.
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // Nothing is accepted during the bitmap clearing pass.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_busy |-> !i_in.ready)
        else $error("input ready during bitmap clear");

    // An accepted transaction makes the block busy on the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready && !o_out.valid)
        else $error("block not busy after accept");

endmodule
`default_nettype wire
